// ----- design/wait_die_rw_lock_queue_macros.svh -----
// ----------------------------------------------------------------------------
// Wait-die lock queue assertion macros
// Shared assertion helpers for the lock queue RTL.
// ----------------------------------------------------------------------------
`ifndef WAIT_DIE_RW_LOCK_QUEUE_MACROS_SVH
`define WAIT_DIE_RW_LOCK_QUEUE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define WD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WD_ASSERT(label, clk, rst_n, prop, msg)
`define WD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- design/wdrw_pkg.sv -----
// ----------------------------------------------------------------------------
// Wait-die lock queue package
// Shared types and codes for the lock queue.
// ----------------------------------------------------------------------------
package wdrw_pkg;
  localparam logic [1:0] VerdictGrant  = 2'd0;
  localparam logic [1:0] VerdictWait   = 2'd1;
  localparam logic [1:0] VerdictDie    = 2'd2;
  localparam logic [1:0] VerdictCancel = 2'd3;

  localparam logic [1:0] ModeFree  = 2'd0;
  localparam logic [1:0] ModeRead  = 2'd1;
  localparam logic [1:0] ModeWrite = 2'd2;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] prio;
    logic        writer;
    logic        granted;
  } slot_t;

  // per-cell command from the sequencer
  typedef struct packed {
    logic        load;     // write cell at tail index
    logic        shift;    // cell at shift position takes right neighbor
    logic        grant;    // set granted at grant position
  } cell_ctl_t;
endpackage

// ----- design/wdrw_cell.sv -----
// ----------------------------------------------------------------------------
// Lock queue cell
// One queue slot; loads a new request, takes its right neighbor on compaction.
// ----------------------------------------------------------------------------
module wdrw_cell
  import wdrw_pkg::*;
(
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  logic      load_sel_i,
  input  logic      shift_sel_i,
  input  logic      grant_sel_i,
  input  slot_t     new_i,
  input  slot_t     right_i,
  output slot_t     slot_o
);
  slot_t slot_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load && load_sel_i) begin
      slot_q <= new_i;
    end else if (ctl_i.shift && shift_sel_i) begin
      slot_q <= right_i;
    end else if (ctl_i.grant && grant_sel_i) begin
      slot_q.granted <= 1'b1;
    end
  end

  assign slot_o = slot_q;
endmodule

// ----- design/wait_die_rw_lock_queue.sv -----
// ----------------------------------------------------------------------------
// Wait-die reader-writer lock queue
// A lock scans the queued entries from the tail toward the head; a release
// finds its entry, compacts the queue over it and hands the lock on. A
// sequencer walks the row of queue cells one slot a cycle and compacts it
// one shift a cycle. Results appear at most one per cycle on done_o, each
// for one cycle; the receiver cannot stall, so nothing is held back.
// ----------------------------------------------------------------------------
`include "wait_die_rw_lock_queue_macros.svh"
module wait_die_rw_lock_queue
  import wdrw_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic        lock_kind_i,
  input  logic [31:0] priority_req_i,
  input  logic [31:0] target_id_i,
  output logic        done_o,
  output logic [31:0] request_id_o,
  output logic [1:0]  verdict_o,
  output logic        last_result_o
);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StLScan   = 4'd1;
  localparam logic [3:0] StLDone   = 4'd2;
  localparam logic [3:0] StRFind   = 4'd3;
  localparam logic [3:0] StRShift  = 4'd4;
  localparam logic [3:0] StRRun    = 4'd5;
  localparam logic [3:0] StRFin    = 4'd6;
  localparam logic [3:0] StRHand   = 4'd7;

  slot_t     slots [QUEUE_DEPTH];
  cell_ctl_t ctl;
  slot_t     new_slot;
  logic [IW-1:0] load_idx, shift_idx, grant_idx;

  logic [3:0]    st_q, st_d;
  logic [CW-1:0] len_q, len_d;
  logic [1:0]    mode_q, mode_d;
  logic [CW-1:0] hold_q, hold_d, qrd_q, qrd_d, qwr_q, qwr_d;
  logic [31:0]   nid_q, nid_d;
  logic          op_q, wr_q;
  logic [31:0]   prio_q, tgt_q;
  logic [31:0]   cur_id_q, cur_id_d;
  logic [1:0]    vd_q, vd_d;
  logic [CW-1:0] pos_q, pos_d;   // scan/shift index
  logic [CW-1:0] fpos_q, fpos_d; // found position
  logic          wb_q, wb_d;     // writer seen before target
  logic          fgr_q, fgr_d, fwr_q, fwr_d;
  logic          rel_q, rel_d;   // release of a held entry
  logic          out_v_d, out_v_q, out_l_d, out_l_q;
  logic [31:0]   out_id_d, out_id_q;
  logic [1:0]    out_vd_d, out_vd_q;
  slot_t         cur;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    slot_t right;
    if (g == QUEUE_DEPTH - 1) begin : g_end
      assign right = slots[g];
    end else begin : g_mid
      assign right = slots[g+1];
    end
    wdrw_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .load_sel_i  (load_idx == IW'(g)),
      .shift_sel_i (shift_idx == IW'(g)),
      .grant_sel_i (grant_idx == IW'(g)),
      .new_i       (new_slot),
      .right_i     (right),
      .slot_o      (slots[g])
    );
  end

  assign load_idx = len_q[IW-1:0];
  assign cur = slots[pos_q[IW-1:0]];
  assign busy = (st_q != StIdle);

  function automatic logic [CW-1:0] dec_sat(input logic [CW-1:0] v);
    dec_sat = (v != '0) ? v - 1'b1 : '0;
  endfunction

  always_comb begin
    st_d = st_q; len_d = len_q; mode_d = mode_q; hold_d = hold_q;
    qrd_d = qrd_q; qwr_d = qwr_q; nid_d = nid_q; cur_id_d = cur_id_q;
    vd_d = vd_q; pos_d = pos_q; fpos_d = fpos_q; wb_d = wb_q;
    fgr_d = fgr_q; fwr_d = fwr_q; rel_d = rel_q;
    out_v_d = 1'b0; out_l_d = 1'b0; out_id_d = out_id_q; out_vd_d = out_vd_q;
    ctl = '0; shift_idx = pos_q[IW-1:0]; grant_idx = pos_q[IW-1:0];
    new_slot.id = cur_id_q; new_slot.prio = prio_q;
    new_slot.writer = wr_q; new_slot.granted = (vd_q == VerdictGrant);
    unique case (st_q)
      StIdle: begin
        if (start) begin
          if (!operation_i) begin
            cur_id_d = nid_q;
            nid_d = (nid_q == 32'hFFFF_FFFF) ? 32'd1 : nid_q + 32'd1;
            pos_d = len_q;
            if (mode_q == ModeFree ||
                (mode_q == ModeRead && !lock_kind_i && qwr_q == '0)) begin
              vd_d = VerdictGrant; st_d = StLDone;
            end else begin
              vd_d = lock_kind_i ? VerdictWait : VerdictDie; st_d = StLScan;
            end
          end else begin
            pos_d = '0; wb_d = 1'b0; st_d = StRFind;
          end
        end
      end
      StLScan: begin
        if (pos_q == '0) begin
          st_d = StLDone;
        end else begin
          pos_d = pos_q - 1'b1;
          shift_idx = IW'(pos_q - 1'b1);
          if (wr_q) begin
            if (prio_q >= slots[IW'(pos_q - 1'b1)].prio) begin
              vd_d = VerdictDie; st_d = StLDone;
            end else if (slots[IW'(pos_q - 1'b1)].writer) begin
              st_d = StLDone;
            end
          end else if (slots[IW'(pos_q - 1'b1)].writer) begin
            vd_d = (prio_q < slots[IW'(pos_q - 1'b1)].prio) ? VerdictWait : VerdictDie;
            st_d = StLDone;
          end
        end
      end
      StLDone: begin
        out_v_d = 1'b1; out_l_d = 1'b1; out_id_d = cur_id_q; out_vd_d = vd_q;
        st_d = StIdle;
        if (vd_q != VerdictDie) begin
          if (len_q >= CW'(QUEUE_DEPTH)) begin
            out_vd_d = VerdictDie;
          end else begin
            ctl.load = 1'b1;
            len_d = len_q + 1'b1;
            if (wr_q) qwr_d = qwr_q + 1'b1; else qrd_d = qrd_q + 1'b1;
            if (vd_q == VerdictGrant) begin
              if (wr_q) mode_d = ModeWrite;
              else begin mode_d = ModeRead; hold_d = hold_q + 1'b1; end
            end
          end
        end
      end
      StRFind: begin
        if (pos_q >= len_q) begin
          st_d = StIdle;
        end else if (cur.id == tgt_q) begin
          fpos_d = pos_q; fgr_d = cur.granted; fwr_d = cur.writer;
          st_d = StRShift;
          if (!cur.granted) begin
            rel_d = 1'b0;
            if (cur.writer) qwr_d = dec_sat(qwr_q); else qrd_d = dec_sat(qrd_q);
          end else begin
            rel_d = 1'b1;
            if (cur.writer) qwr_d = dec_sat(qwr_q);
            else begin qrd_d = dec_sat(qrd_q); hold_d = dec_sat(hold_q); end
          end
        end else begin
          if (cur.writer) wb_d = 1'b1;
          pos_d = pos_q + 1'b1;
        end
      end
      StRShift: begin
        if (pos_q + 1'b1 < len_q) begin
          ctl.shift = 1'b1; pos_d = pos_q + 1'b1;
        end else begin
          len_d = len_q - 1'b1; pos_d = fpos_q;
          if (!rel_q) st_d = (fwr_q && !wb_q) ? StRRun : StRFin;
          else st_d = (!fwr_q && hold_q != '0) ? StIdle : StRHand;
        end
      end
      StRHand: begin
        if (len_q == '0) begin
          mode_d = ModeFree; st_d = StIdle;
        end else if (pos_q >= len_q) begin
          st_d = StIdle;
        end else if (cur.writer) begin
          st_d = StIdle;
          if (!cur.granted) begin
            ctl.grant = 1'b1; mode_d = ModeWrite;
            out_v_d = 1'b1; out_l_d = 1'b1; out_id_d = cur.id; out_vd_d = VerdictGrant;
          end
        end else begin
          st_d = StRRun;
        end
      end
      StRRun: begin
        if (pos_q >= len_q || cur.writer) begin
          st_d = rel_q ? StIdle : StRFin;
          if (rel_q && out_v_q) out_l_d = 1'b0;
        end else begin
          pos_d = pos_q + 1'b1;
          if (!cur.granted) begin
            ctl.grant = 1'b1; hold_d = hold_q + 1'b1; mode_d = ModeRead;
            out_v_d = 1'b1; out_id_d = cur.id; out_vd_d = VerdictGrant;
            out_l_d = rel_q && ((pos_q + 1'b1 >= len_q) ||
                                slots[IW'(pos_q + 1'b1)].writer);
            if (out_l_d) st_d = StIdle;
          end
        end
      end
      StRFin: begin
        out_v_d = 1'b1; out_l_d = 1'b1; out_id_d = tgt_q; out_vd_d = VerdictCancel;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; len_q <= '0; mode_q <= ModeFree; hold_q <= '0;
      qrd_q <= '0; qwr_q <= '0; nid_q <= 32'd1; out_v_q <= 1'b0;
    end else begin
      st_q <= st_d; len_q <= len_d; mode_q <= mode_d; hold_q <= hold_d;
      qrd_q <= qrd_d; qwr_q <= qwr_d; nid_q <= nid_d; out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q <= operation_i; wr_q <= lock_kind_i;
      prio_q <= priority_req_i; tgt_q <= target_id_i;
    end
    cur_id_q <= cur_id_d; vd_q <= vd_d; pos_q <= pos_d; fpos_q <= fpos_d;
    wb_q <= wb_d; fgr_q <= fgr_d; fwr_q <= fwr_d; rel_q <= rel_d;
    out_l_q <= out_l_d; out_id_q <= out_id_d; out_vd_q <= out_vd_d;
  end

  assign done_o = out_v_q;
  assign request_id_o = out_id_q;
  assign verdict_o = out_vd_q;
  assign last_result_o = out_l_q;

  `WD_ASSERT(a_len_bound, clk_i, rst_ni, len_q <= CW'(QUEUE_DEPTH), "queue overflow")
  `WD_ASSERT(a_free_empty, clk_i, rst_ni, (st_q != StIdle) || (mode_q != ModeFree) || (len_q == '0) || op_q || fgr_q, "free lock with entries")
  `WD_ASSERT_NEXT(a_id_nz, clk_i, rst_ni, 1'b1, nid_q != 32'd0, "request id zero")
endmodule

// ----- dv/wait_die_rw_lock_queue_tb.sv -----
// ----------------------------------------------------------------------------
// Wait-die lock queue testbench
// Drives lock and release requests through the start/busy handshake and
// checks every strobed result against a behavioral model of the queue.
// ----------------------------------------------------------------------------
module wait_die_rw_lock_queue_tb
  import wdrw_pkg::*;
();

  localparam int Depth = 16;
  localparam int WatchdogLimit = 20000;
  localparam logic OpLock = 1'b0;
  localparam logic OpRelease = 1'b1;
  localparam logic KindRead = 1'b0;
  localparam logic KindWrite = 1'b1;

  typedef struct packed {
    logic [31:0] id;
    logic [1:0]  verdict;
    logic        last;
  } lock_result_t;

  class lock_scoreboard;
    slot_t        slots[$];
    logic [1:0]   mode;
    int unsigned  holders;
    int unsigned  rd_queued;
    int unsigned  wr_queued;
    logic [31:0]  next_id;
    lock_result_t pending[$];
    lock_result_t step_out[$];
    int           errors;

    function void clear();
      slots.delete();
      pending.delete();
      mode = ModeFree;
      holders = 0;
      rd_queued = 0;
      wr_queued = 0;
      next_id = 32'd1;
      errors = 0;
    endfunction

    function void post(logic [31:0] id, logic [1:0] v);
      lock_result_t r;
      r.id = id;
      r.verdict = v;
      r.last = 1'b0;
      step_out = {step_out, r};
    endfunction

    function void grant_readers(int pos);
      for (int i = pos; i < slots.size() && !slots[i].writer; i++) begin
        if (!slots[i].granted) begin
          slots[i].granted = 1'b1;
          holders++;
          mode = ModeRead;
          post(slots[i].id, VerdictGrant);
        end
      end
    endfunction

    function void pass_on(int pos);
      if (slots.size() == 0) begin
        mode = ModeFree;
        return;
      end
      if (pos >= slots.size()) return;
      if (slots[pos].writer) begin
        if (!slots[pos].granted) begin
          slots[pos].granted = 1'b1;
          mode = ModeWrite;
          post(slots[pos].id, VerdictGrant);
        end
      end else begin
        grant_readers(pos);
      end
    endfunction

    function logic [1:0] age_check(logic wr, logic [31:0] prio);
      for (int i = slots.size() - 1; i >= 0; i--) begin
        if (wr) begin
          if (prio >= slots[i].prio) return VerdictDie;
          if (slots[i].writer) break;
        end else if (slots[i].writer) begin
          return (prio < slots[i].prio) ? VerdictWait : VerdictDie;
        end
      end
      return wr ? VerdictWait : VerdictDie;
    endfunction

    function void enqueue(logic [31:0] id, logic [31:0] prio, logic wr, logic g);
      slot_t s;
      s.id = id;
      s.prio = prio;
      s.writer = wr;
      s.granted = g;
      slots = {slots, s};
      if (wr) wr_queued++;
      else rd_queued++;
    endfunction

    function void note_request(logic op, logic wr, logic [31:0] prio, logic [31:0] tgt);
      logic [31:0] id;
      logic [1:0]  v;
      int          pos;
      int          wr_before;
      logic        was_wr;
      step_out.delete();
      if (op == OpLock) begin
        id = next_id;
        next_id = (next_id == 32'hFFFF_FFFF) ? 32'd1 : next_id + 32'd1;
        if (mode == ModeFree || (mode == ModeRead && !wr && wr_queued == 0)) begin
          if (slots.size() >= Depth) begin
            v = VerdictDie;
          end else begin
            enqueue(id, prio, wr, 1'b1);
            if (wr) begin
              mode = ModeWrite;
            end else begin
              mode = ModeRead;
              holders++;
            end
            v = VerdictGrant;
          end
        end else begin
          v = age_check(wr, prio);
          if (v == VerdictWait) begin
            if (slots.size() >= Depth) v = VerdictDie;
            else enqueue(id, prio, wr, 1'b0);
          end
        end
        post(id, v);
      end else begin
        wr_before = 0;
        pos = -1;
        for (int i = 0; i < slots.size(); i++) begin
          if (slots[i].id == tgt) begin
            pos = i;
            break;
          end
          if (slots[i].writer) wr_before++;
        end
        if (pos >= 0) begin
          was_wr = slots[pos].writer;
          if (!slots[pos].granted) begin
            slots.delete(pos);
            if (!was_wr) begin
              rd_queued = (rd_queued > 0) ? rd_queued - 1 : 0;
            end else begin
              wr_queued = (wr_queued > 0) ? wr_queued - 1 : 0;
              if (wr_before == 0) grant_readers(pos);
            end
            post(tgt, VerdictCancel);
          end else if (!was_wr) begin
            rd_queued = (rd_queued > 0) ? rd_queued - 1 : 0;
            holders = (holders > 0) ? holders - 1 : 0;
            slots.delete(pos);
            if (holders == 0) pass_on(pos);
          end else begin
            wr_queued = (wr_queued > 0) ? wr_queued - 1 : 0;
            slots.delete(pos);
            pass_on(pos);
          end
        end
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) pending = {pending, step_out[i]};
    endfunction

    function void check_result(lock_result_t got);
      lock_result_t exp;
      if (pending.size() == 0) begin
        report("unexpected result", got, got);
        return;
      end
      exp = pending.pop_front();
      if (got.id !== exp.id) report("request_id", got, exp);
      if (got.verdict !== exp.verdict) report("verdict", got, exp);
      if (got.last !== exp.last) report("last_result", got, exp);
    endfunction

    function void report(string what, lock_result_t got, lock_result_t exp);
      $display("mismatch %s: got id %0d v %0d last %0b, exp id %0d v %0d last %0b",
               what, got.id, got.verdict, got.last, exp.id, exp.verdict, exp.last);
      errors++;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        operation_i;
  logic        lock_kind_i;
  logic [31:0] priority_req_i;
  logic [31:0] target_id_i;
  logic        done_o;
  logic [31:0] request_id_o;
  logic [1:0]  verdict_o;
  logic        last_result_o;

  lock_scoreboard sb;
  int            idle_pct;
  int            quiet_cycles = 0;
  logic [31:0]   issued;

  wait_die_rw_lock_queue #(.QUEUE_DEPTH(Depth)) dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .operation_i,
    .lock_kind_i,
    .priority_req_i,
    .target_id_i,
    .done_o,
    .request_id_o,
    .verdict_o,
    .last_result_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result({request_id_o, verdict_o, last_result_o});
      if ((start && !busy) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send(logic op, logic wr, logic [31:0] prio, logic [31:0] tgt);
    while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    start <= 1'b1;
    operation_i <= op;
    lock_kind_i <= wr;
    priority_req_i <= prio;
    target_id_i <= tgt;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(op, wr, prio, tgt);
    if (op == OpLock) issued = issued + 32'd1;
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2 * Depth + 8) @(posedge clk_i);
  endtask

  task automatic random_request();
    int r;
    logic [31:0] tgt;
    r = $urandom_range(99);
    if (sb.slots.size() > 0 && r < 45) begin
      tgt = sb.slots[$urandom_range(sb.slots.size() - 1)].id;
      send(OpRelease, 1'($urandom_range(1)), $urandom, tgt);
    end else if (r < 50) begin
      tgt = (issued > 3) ? issued - $urandom_range(3) : $urandom;
      send(OpRelease, 1'($urandom_range(1)), $urandom, tgt);
    end else if (r < 55) begin
      send(OpLock, 1'($urandom_range(1)), $urandom, $urandom);
    end else begin
      send(OpLock, 1'($urandom_range(1)), $urandom_range(200), $urandom);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    issued = 32'd0;
    idle_pct = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    operation_i = OpLock;
    lock_kind_i = KindRead;
    priority_req_i = '0;
    target_id_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(OpRelease, KindRead, 32'd0, 32'd0);
    send(OpLock, KindRead, 32'd100, 32'hFFFF_FFFF);
    send(OpLock, KindRead, 32'd50, 32'd0);
    send(OpLock, KindWrite, 32'd10, 32'd0);
    send(OpLock, KindRead, 32'd5, 32'd0);
    send(OpLock, KindRead, 32'hFFFF_FFFF, 32'd0);
    send(OpLock, KindWrite, 32'd0, 32'd0);
    send(OpLock, KindWrite, 32'hFFFF_FFFF, 32'd0);
    send(OpRelease, KindRead, 32'd0, 32'd3);
    send(OpRelease, KindRead, 32'd0, 32'd1);
    send(OpRelease, KindRead, 32'd0, 32'd2);
    send(OpRelease, KindRead, 32'd0, 32'd7);
    send(OpRelease, KindRead, 32'd0, 32'd5);
    send(OpRelease, KindRead, 32'd0, 32'hFFFF_FFFF);
    send(OpLock, KindWrite, 32'd1000, 32'd0);
    for (int i = 0; i < 17; i++) send(OpLock, KindWrite, 32'd999 - i, 32'd0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 7 : (phase == 1) ? 72 : 0;
      for (int i = 0; i < 93; i++) begin
        random_request();
        if (i == 50) drain();
      end
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
